/* hdl/dbc_pkg.sv */
package dbc_pkg;

  localparam int SWITCH_COUNT_DEFAULT = 8;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;
  // Only eight switches have an input bit and an enable bit.
  localparam int MAX_LANES            = 8;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_DEBOUNCE_US   = cfg_index_t'(0);
  localparam cfg_index_t CFG_SWITCH_ENABLE = cfg_index_t'(1);

  localparam logic [15:0] DEBOUNCE_RESET = 16'd1000;
  localparam logic [7:0]  ENABLE_RESET   = 8'h00;

  typedef struct packed {
    logic [15:0] debounce_us;
    logic [7:0]  switch_enable;
  } dbc_cfg_t;

  typedef struct packed {
    logic [2:0] switch_index;
    logic       pressed;
    logic       last;
  } dbc_event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } front_state_t;

endpackage

/* hdl/dbc_if.sv */
interface dbc_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink (input valid, input raw_levels, output ready);
endinterface

interface dbc_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] switch_index;
  logic       pressed;
  logic       last;

  modport source (output valid, output switch_index, output pressed, output last,
                  input ready);
  modport sink (input valid, input switch_index, input pressed, input last,
                output ready);
endinterface

interface dbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/multi_switch_debouncer_core.sv */
// Channel   Role   Payload                          Transaction
// cfg       sink   index[3:0], data[15:0]           valid && ready, ready always high
// tick      sink   raw_levels[7:0]                  valid && ready, one microsecond tick
// events    source switch_index[2:0], pressed, last valid && ready, one per level change
//
// The front scans one switch per cycle unless a full queue stalls it. A tick takes it from
// the accepting cycle through a scan step per switch to ST_FLUSH, which releases the final event.
// Events go through a QUEUE_DEPTH entry queue to a registered output stage.
// A full queue stalls the scan only when the front has a second event to hand over.
// Reset (rst, synchronous) restores the register defaults and the per-switch history.
module multi_switch_debouncer_core #(
  parameter int SWITCH_COUNT = dbc_pkg::SWITCH_COUNT_DEFAULT,
  parameter int QUEUE_DEPTH  = dbc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  dbc_cfg_if.sink     cfg,
  dbc_tick_if.sink    tick,
  dbc_event_if.source events
);
  import dbc_pkg::*;

  localparam int LANES = (SWITCH_COUNT < MAX_LANES) ? SWITCH_COUNT : MAX_LANES;

  dbc_cfg_t   cfg_q;
  logic       push, pop, queue_full, queue_empty;
  dbc_event_t push_data, pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.debounce_us   <= DEBOUNCE_RESET;
      cfg_q.switch_enable <= ENABLE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DEBOUNCE_US:   cfg_q.debounce_us   <= cfg.data;
        CFG_SWITCH_ENABLE: cfg_q.switch_enable <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  dbc_front #(
    .LANES(LANES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .cfg        (cfg_q),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  dbc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  dbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .events      (events)
  );

endmodule

/* hdl/dbc_front.sv */
module dbc_front #(
  parameter int LANES = 8
) (
  input  logic                clk,
  input  logic                rst,
  dbc_tick_if.sink            tick,
  input  dbc_pkg::dbc_cfg_t   cfg,
  output logic                push,
  output dbc_pkg::dbc_event_t push_data,
  input  logic                queue_full
);
  import dbc_pkg::*;

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  front_state_t state, state_next;

  logic [IDX_W-1:0] idx;
  logic [LANES-1:0] raw_q;
  logic [31:0]      now_counter;
  logic [31:0]      tick_time;
  logic [31:0]      tick_deadline;

  logic [LANES-1:0] prev_raw;
  logic [LANES-1:0] acc_level;
  logic [LANES-1:0] pending;
  logic [31:0]      accept_time [LANES];
  logic [31:0]      deadline    [LANES];

  logic       hold_valid;
  logic [2:0] hold_idx;
  logic       hold_lvl;

  logic        cur_bit, cur_lvl, cur_en;
  logic        lane_edge, too_soon, recheck_due, lane_event;
  logic        step_ok, last_lane, tick_take;
  logic [31:0] elapsed;

  always_comb begin
    cur_bit     = raw_q[idx];
    cur_lvl     = ~cur_bit;
    cur_en      = cfg.switch_enable[idx];
    lane_edge   = cur_en && (cur_bit != prev_raw[idx]) && (cur_lvl != acc_level[idx]);
    elapsed     = tick_time - accept_time[idx];
    too_soon    = elapsed < {16'd0, cfg.debounce_us};
    // A qualifying edge either cancels the re-check or moves it into the future.
    recheck_due = cur_en && !lane_edge && pending[idx] && (deadline[idx] == tick_time);
    lane_event  = (lane_edge && !too_soon) || (recheck_due && (cur_lvl != acc_level[idx]));
    last_lane   = (idx == IDX_W'(LANES - 1));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (tick.valid) state_next = ST_SCAN;
      ST_SCAN:  if (step_ok && last_lane) state_next = ST_FLUSH;
      ST_FLUSH: if (!hold_valid || !queue_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs. An event waits in the hold register until the next one shows up
  // or the scan ends, so that the final event of a tick can carry last.
  always_comb begin
    tick.ready = 1'b0;
    step_ok    = 1'b0;
    push       = 1'b0;
    push_data  = '{switch_index: hold_idx, pressed: hold_lvl, last: 1'b0};
    unique case (state)
      ST_IDLE: tick.ready = 1'b1;
      ST_SCAN: begin
        step_ok = !lane_event || !hold_valid || !queue_full;
        push    = lane_event && hold_valid && !queue_full;
      end
      ST_FLUSH: begin
        push           = hold_valid && !queue_full;
        push_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  assign tick_take = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      now_counter <= '0;
      prev_raw    <= '1;
      acc_level   <= '0;
      pending     <= '0;
      hold_valid  <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        accept_time[i] <= '0;
        deadline[i]    <= '0;
      end
    end else begin
      state <= state_next;
      if (tick_take) begin
        raw_q         <= tick.raw_levels[LANES-1:0];
        tick_time     <= now_counter;
        tick_deadline <= now_counter + 32'(cfg.debounce_us);
        now_counter   <= now_counter + 32'd1;
        idx           <= '0;
      end
      if (step_ok) begin
        prev_raw[idx] <= cur_bit;
        if (lane_edge) begin
          if (too_soon) begin
            pending[idx]  <= 1'b1;
            deadline[idx] <= tick_deadline;
          end else begin
            pending[idx]     <= 1'b0;
            accept_time[idx] <= tick_time;
            acc_level[idx]   <= cur_lvl;
          end
        end else if (recheck_due) begin
          pending[idx]   <= 1'b0;
          acc_level[idx] <= cur_lvl;
        end
        if (lane_event) begin
          hold_valid <= 1'b1;
          hold_idx   <= 3'(idx);
          hold_lvl   <= cur_lvl;
        end
        if (!last_lane) idx <= idx + IDX_W'(1);
      end
      if (state == ST_FLUSH && !queue_full) hold_valid <= 1'b0;
    end
  end

  a_idle_empty_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !hold_valid)
    else $error("front idle with an event still held");

  a_time_advance: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> now_counter == $past(now_counter) + 32'd1)
    else $error("time did not advance by one on a tick");

  a_push_from_hold: assert property (@(posedge clk) disable iff (rst)
    push |-> hold_valid && !queue_full)
    else $error("push without a held event or into a full queue");

endmodule

/* hdl/dbc_queue.sv */
module dbc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dbc_pkg::dbc_event_t push_data,
  output logic                full,
  input  logic                pop,
  output dbc_pkg::dbc_event_t pop_data,
  output logic                empty
);
  import dbc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbc_event_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");

endmodule

/* hdl/dbc_back.sv */
module dbc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                queue_empty,
  input  dbc_pkg::dbc_event_t queue_data,
  output logic                pop,
  dbc_event_if.source         events
);
  import dbc_pkg::*;

  logic       out_valid;
  dbc_event_t out_data;

  // Refill the output register whenever it is empty or being taken.
  assign pop = !queue_empty && (!out_valid || events.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= queue_data;
  end

  assign events.valid        = out_valid;
  assign events.switch_index = out_data.switch_index;
  assign events.pressed      = out_data.pressed;
  assign events.last         = out_data.last;

endmodule

/* tb/dbc_event_checker.sv */
module dbc_event_checker (
  input  logic clk,
  input  logic rst,
  dbc_cfg_if   cfg,
  dbc_tick_if  tick,
  dbc_event_if events,
  output int   fail_count,
  output int   pending_count,
  output int   tick_total,
  output int   event_total,
  output int   recheck_total
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  logic [15:0] debounce_q;
  logic [7:0]  enable_q;

  logic [31:0]          now_q;
  logic [MAX_LANES-1:0] prev_raw_q;
  logic [MAX_LANES-1:0] level_q;
  logic [MAX_LANES-1:0] recheck_q;
  logic [31:0]          accept_time_q [MAX_LANES];
  logic [31:0]          deadline_q [MAX_LANES];

  dbc_event_t expected_events [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 30) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Advances the per-switch history by one microsecond tick and queues the
  // level changes it causes, lowest switch first.
  task automatic debounce_tick(input logic [7:0] raw);
    dbc_event_t  found [MAX_LANES];
    int          n;
    logic        lvl;
    logic [31:0] elapsed;
    n = 0;
    for (int i = 0; i < MAX_LANES; i++) begin
      lvl = ~raw[i];
      if (enable_q[i]) begin
        if (raw[i] != prev_raw_q[i] && lvl != level_q[i]) begin
          recheck_q[i] = 1'b0;
          elapsed = now_q - accept_time_q[i];
          if (elapsed < {16'h0000, debounce_q}) begin
            recheck_q[i] = 1'b1;
            deadline_q[i] = now_q + {16'h0000, debounce_q};
          end else begin
            accept_time_q[i] = now_q;
            level_q[i] = lvl;
            found[n] = '{switch_index: 3'(i), pressed: lvl, last: 1'b0};
            n++;
          end
        end
        // A delayed re-check takes the level it sees but keeps the timestamp.
        if (recheck_q[i] && deadline_q[i] == now_q) begin
          recheck_q[i] = 1'b0;
          if (lvl != level_q[i]) begin
            level_q[i] = lvl;
            found[n] = '{switch_index: 3'(i), pressed: lvl, last: 1'b0};
            n++;
            recheck_total++;
          end
        end
      end
      prev_raw_q[i] = raw[i];
    end
    for (int k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      expected_events.push_back(found[k]);
    end
    now_q = now_q + 32'd1;
  endtask

  always @(posedge clk) begin
    dbc_event_t want;
    if (rst) begin
      debounce_q = DEBOUNCE_RESET;
      enable_q   = ENABLE_RESET;
      now_q      = '0;
      prev_raw_q = '1;
      level_q    = '0;
      recheck_q  = '0;
      for (int i = 0; i < MAX_LANES; i++) begin
        accept_time_q[i] = '0;
        deadline_q[i]    = '0;
      end
      expected_events.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_DEBOUNCE_US:   debounce_q = cfg.data;
          CFG_SWITCH_ENABLE: enable_q = cfg.data[7:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        debounce_tick(tick.raw_levels);
        tick_total++;
      end
      if (events.valid && events.ready) begin
        event_total++;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event: switch %0d pressed %0b last %0b",
                                    events.switch_index, events.pressed, events.last));
        end else begin
          want = expected_events.pop_front();
          if (events.switch_index !== want.switch_index)
            report_mismatch($sformatf("switch_index %0d, expected %0d",
                                      events.switch_index, want.switch_index));
          if (events.pressed !== want.pressed)
            report_mismatch($sformatf("pressed %0b on switch %0d, expected %0b",
                                      events.pressed, want.switch_index, want.pressed));
          if (events.last !== want.last)
            report_mismatch($sformatf("last %0b on switch %0d, expected %0b",
                                      events.last, want.switch_index, want.last));
        end
      end
    end
    pending_count = expected_events.size();
  end

endmodule

/* tb/tb_multi_switch_debouncer_core.sv */
module tb_multi_switch_debouncer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         RANDOM_TICKS  = 446;
  localparam cfg_index_t CFG_UNUSED    = cfg_index_t'(15);

  logic clk = 1'b0;
  logic rst = 1'b1;

  int idle_pct;
  int stall_pct;
  int cycle_count;
  int settings_used;

  int fail_count;
  int pending;
  int tick_total;
  int event_total;
  int recheck_total;

  dbc_cfg_if   cfg_ch ();
  dbc_tick_if  tick_ch ();
  dbc_event_if event_ch ();

  multi_switch_debouncer_core dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .tick   (tick_ch),
    .events (event_ch)
  );

  dbc_event_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .tick          (tick_ch),
    .events        (event_ch),
    .fail_count    (fail_count),
    .pending_count (pending),
    .tick_total    (tick_total),
    .event_total   (event_total),
    .recheck_total (recheck_total)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d events outstanding.", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) event_ch.ready <= ($urandom_range(99) >= stall_pct);

  // Each sender task starts and ends at a falling edge; valid is left high so
  // that back-to-back transactions never lower and raise it in one step.
  task automatic send_tick(input logic [7:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.raw_levels <= raw;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain(input int settle);
    tick_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // A tick may still be in the scan without any event pending, so the block
  // gets extra cycles to go idle before its registers change.
  task automatic apply_setting(input logic [15:0] deb, input logic [7:0] en,
                               input bit poke_unused);
    drain(SETTLE_CYCLES);
    write_reg(CFG_DEBOUNCE_US, deb);
    if (poke_unused) write_reg(CFG_UNUSED, ~deb);
    write_reg(CFG_SWITCH_ENABLE, {8'h00, en});
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0]  pins;
    logic [15:0] deb;
    logic [7:0]  en;
    int          seg;
    int          len;
    int          roll;
    int          random_sent;

    tick_ch.valid      = 1'b0;
    tick_ch.raw_levels = 8'hFF;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_DEBOUNCE_US;
    cfg_ch.data        = 16'h0000;
    event_ch.ready     = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: every switch disabled, only the pin history moves.
    send_tick(8'h00);

    // Zero hold-off accepts every differing edge at once.
    apply_setting(16'h0000, 8'hFF, 1'b0);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hAA);
    send_tick(8'h55);
    send_tick(8'hFF);

    // Short hold-off: bounces inside the window become re-checks.
    apply_setting(16'd3, 8'hFF, 1'b1);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hF0);

    // Longest hold-off schedules re-checks that stay frozen once disabled.
    apply_setting(16'hFFFF, 8'hA5, 1'b0);
    send_tick(8'h0F);
    send_tick(8'hF0);
    send_tick(8'h00);
    apply_setting(16'd1, 8'h5A, 1'b0);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h3C);

    pins        = 8'h3C;
    seg         = 0;
    random_sent = 0;
    while (random_sent < RANDOM_TICKS) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (seg % 6 == 4) begin
        deb = 16'hFFFF;
        len = 12;
      end else if (seg % 6 == 1) begin
        deb = 16'h0000;
        len = $urandom_range(20, 40);
      end else begin
        deb = 16'($urandom_range(1, 12));
        len = $urandom_range(25, 60);
      end
      en = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
      if (seg % 9 == 7) en = 8'h00;
      apply_setting(deb, en, seg % 5 == 2);
      for (int k = 0; k < len && random_sent < RANDOM_TICKS; k++) begin
        if (k == len / 2 && seg % 3 == 0) drain(0);
        // Mostly switches chattering a few bits at a time, with some steady
        // stretches and some fully random pin noise.
        roll = $urandom_range(99);
        if (roll < 12) begin
          pins = 8'($urandom);
        end else if (roll >= 30) begin
          for (int i = 0; i < 8; i++)
            if ($urandom_range(4) == 0) pins[i] = ~pins[i];
        end
        send_tick(pins);
        random_sent++;
      end
      seg++;
    end

    drain(SETTLE_CYCLES);
    $display("Sent %0d ticks over %0d register settings; checked %0d switch events,",
             tick_total, settings_used, event_total);
    $display("%0d of them from delayed re-checks, under four idle and stall mixes.",
             recheck_total);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d events never seen.", fail_count, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
